>>> rtl/core/wheel_odo_pkg.sv
`timescale 1ns / 1ps

package wheel_odo_pkg;

    // field widths
    localparam int COUNT_W   = 16;
    localparam int ELAPSED_W = 16;
    localparam int MARK_W    = 16;
    localparam int SPAN_W    = 17;
    localparam int RPT_W     = 32;
    localparam int PAUSE_W   = 16;
    localparam int WRAPS_W   = 16;
    localparam int OUT_W     = 48;

    localparam int ACCUM_WIDTH_DEFAULT = 48;

    // wraps * span + raw fits in 34 signed bits
    localparam int POS_W = 34;

    // only product bits [63:16] reach the angle outputs
    localparam int ANGLE_SHIFT = 16;
    localparam int PROD_W      = ANGLE_SHIFT + OUT_W;

    // scale multiplier: one digit of radians_per_tick per cycle
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = RPT_W / DIGIT_W;
    localparam int STEP_W    = $clog2(MUL_STEPS);

    localparam int NEAR_ZERO = 5;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_WRAP_LOW_MARK    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WRAP_HIGH_MARK   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUNT_SPAN       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIANS_PER_TICK = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PAUSE_LIMIT_MS   = 3'd4;

    localparam logic signed [MARK_W-1:0] WRAP_LOW_MARK_RST    = 16'sd2700;
    localparam logic signed [MARK_W-1:0] WRAP_HIGH_MARK_RST   = 16'sd6300;
    localparam logic        [SPAN_W-1:0] COUNT_SPAN_RST       = 17'd9000;
    localparam logic        [RPT_W-1:0]  RADIANS_PER_TICK_RST = 32'd299845283;
    localparam logic        [PAUSE_W-1:0] PAUSE_LIMIT_MS_RST  = 16'd200;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count_left;
        logic signed [COUNT_W-1:0] count_right;
        logic [ELAPSED_W-1:0]      elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] ticks_left;
        logic signed [OUT_W-1:0] ticks_right;
        logic signed [OUT_W-1:0] angle_left;
        logic signed [OUT_W-1:0] angle_right;
        logic                    restart_seen;
    } result_t;

endpackage

>>> rtl/core/wheel_encoder_unwrap_odometry.sv
`timescale 1ns / 1ps

// Wheel encoder unwrap and odometry accumulator.
// sample channel (sample_valid / sample_stall / sample): one pair of raw
// wrapping wheel counts plus the milliseconds since the previous reading.
// result channel (result_valid / result_stall / result): accumulated ticks,
// the matching angles in Q32.16 radians and a restart flag, one per sample.
// Registers sit on an APB-style port at byte addresses 0, 4, 8, 12, 16.
// A sample passes the position, accumulate, multiply and output states in
// that order before result_valid rises; sample_stall holds off the next
// sample until then. The scale multiplier walks radians_per_tick one 4-bit
// digit per cycle, both wheels side by side.
// A new sample is taken while the previous result still waits in the
// output register. While result_stall holds, the result stays put; the
// next sample is finished and then parked until the register frees up.
// Reset loads the default register values, clears wrap counters, stored
// positions and accumulators, and marks the next sample as the first one.
module wheel_encoder_unwrap_odometry #(
    parameter int ACCUM_WIDTH = wheel_odo_pkg::ACCUM_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  wheel_odo_pkg::sample_t              sample,

    output logic                                result_valid,
    input  logic                                result_stall,
    output wheel_odo_pkg::result_t              result,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wheel_odo_pkg::ADDR_W-1:0]    paddr,
    input  logic [wheel_odo_pkg::DATA_W-1:0]    pwdata,
    output logic [wheel_odo_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int COUNT_W   = wheel_odo_pkg::COUNT_W;
    localparam int MARK_W    = wheel_odo_pkg::MARK_W;
    localparam int SPAN_W    = wheel_odo_pkg::SPAN_W;
    localparam int RPT_W     = wheel_odo_pkg::RPT_W;
    localparam int PAUSE_W   = wheel_odo_pkg::PAUSE_W;
    localparam int WRAPS_W   = wheel_odo_pkg::WRAPS_W;
    localparam int OUT_W     = wheel_odo_pkg::OUT_W;
    localparam int POS_W     = wheel_odo_pkg::POS_W;
    localparam int PROD_W    = wheel_odo_pkg::PROD_W;
    localparam int DIGIT_W   = wheel_odo_pkg::DIGIT_W;
    localparam int STEP_W    = wheel_odo_pkg::STEP_W;
    localparam int DATA_W    = wheel_odo_pkg::DATA_W;
    localparam int REG_IDX_W = wheel_odo_pkg::REG_IDX_W;
    localparam int ADDR_W_HI = wheel_odo_pkg::ADDR_W - 1;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wheel_odo_pkg::MUL_STEPS - 1);
    localparam logic signed [POS_W-1:0] NEAR_HI = POS_W'(wheel_odo_pkg::NEAR_ZERO);
    localparam logic signed [POS_W-1:0] NEAR_LO = -NEAR_HI;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POS  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    // configuration
    logic signed [MARK_W-1:0] low_mark_reg, low_mark_next;
    logic signed [MARK_W-1:0] high_mark_reg, high_mark_next;
    logic [SPAN_W-1:0]        span_reg, span_next;
    logic [RPT_W-1:0]         rpt_reg, rpt_next;
    logic [PAUSE_W-1:0]       pause_reg, pause_next;

    // wheel state
    logic signed [WRAPS_W-1:0] wraps_l_reg, wraps_l_next;
    logic signed [WRAPS_W-1:0] wraps_r_reg, wraps_r_next;
    logic signed [COUNT_W-1:0] prev_l_reg, prev_l_next;
    logic signed [COUNT_W-1:0] prev_r_reg, prev_r_next;
    logic signed [POS_W-1:0]   ref_l_reg, ref_l_next;
    logic signed [POS_W-1:0]   ref_r_reg, ref_r_next;
    logic [ACCUM_WIDTH-1:0]    accum_l_reg, accum_l_next;
    logic [ACCUM_WIDTH-1:0]    accum_r_reg, accum_r_next;
    logic                      first_item_reg, first_item_next;

    // per-sample datapath
    logic signed [COUNT_W-1:0] raw_l_reg, raw_l_next;
    logic signed [COUNT_W-1:0] raw_r_reg, raw_r_next;
    logic                      pause_hit_reg, pause_hit_next;
    logic signed [POS_W-1:0]   pos_l_reg, pos_l_next;
    logic signed [POS_W-1:0]   pos_r_reg, pos_r_next;
    logic                      restart_reg, restart_next;
    logic [PROD_W-1:0]         mcand_l_reg, mcand_l_next;
    logic [PROD_W-1:0]         mcand_r_reg, mcand_r_next;
    logic [PROD_W-1:0]         prod_l_reg, prod_l_next;
    logic [PROD_W-1:0]         prod_r_reg, prod_r_next;
    logic [RPT_W-1:0]          rpt_sh_reg, rpt_sh_next;
    logic [STEP_W-1:0]         step_reg, step_next;

    wheel_odo_pkg::result_t    result_reg, result_next;
    logic                      result_valid_reg, result_valid_next;

    logic                      sample_take;
    logic                      cfg_write;
    logic [REG_IDX_W-1:0]      cfg_idx;

    // S_POS
    logic signed [POS_W-1:0]   span_ext;
    logic signed [POS_W-1:0]   pos_l_calc, pos_r_calc;
    // S_ACC
    logic                      restart;
    logic signed [POS_W:0]     diff_l, diff_r;
    logic [ACCUM_WIDTH-1:0]    accum_l_sum, accum_r_sum;
    // S_MUL
    logic [DIGIT_W-1:0]        digit;
    logic [PROD_W+DIGIT_W-1:0] pp_l, pp_r;

    function automatic logic signed [WRAPS_W-1:0] wrap_update(
        input logic signed [COUNT_W-1:0] raw,
        input logic signed [COUNT_W-1:0] prev,
        input logic signed [WRAPS_W-1:0] wraps,
        input logic signed [MARK_W-1:0]  low,
        input logic signed [MARK_W-1:0]  high
    );
        logic signed [WRAPS_W-1:0] w;
        w = wraps;
        if (raw < low && prev > high)
        begin
            w = wraps + WRAPS_W'(1);
        end
        else if (raw > high && prev < low)
        begin
            w = wraps - WRAPS_W'(1);
        end
        return w;
    endfunction

    assign sample_take  = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pready       = 1'b1;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W_HI:2];

    always_comb
    begin
        case (cfg_idx)
            wheel_odo_pkg::REG_WRAP_LOW_MARK:    prdata = DATA_W'(low_mark_reg);
            wheel_odo_pkg::REG_WRAP_HIGH_MARK:   prdata = DATA_W'(high_mark_reg);
            wheel_odo_pkg::REG_COUNT_SPAN:       prdata = DATA_W'(span_reg);
            wheel_odo_pkg::REG_RADIANS_PER_TICK: prdata = DATA_W'(rpt_reg);
            wheel_odo_pkg::REG_PAUSE_LIMIT_MS:   prdata = DATA_W'(pause_reg);
            default:                             prdata = '0;
        endcase
    end

    // extended position: raw + wraps * span
    assign span_ext   = POS_W'($signed({1'b0, span_reg}));
    assign pos_l_calc = POS_W'(wraps_l_reg) * span_ext + POS_W'(raw_l_reg);
    assign pos_r_calc = POS_W'(wraps_r_reg) * span_ext + POS_W'(raw_r_reg);

    assign restart = pause_hit_reg
                  && pos_l_reg > NEAR_LO && pos_l_reg < NEAR_HI
                  && pos_r_reg > NEAR_LO && pos_r_reg < NEAR_HI;

    // a restart rebases the reference, the first sample only seeds it
    assign diff_l = (restart || first_item_reg) ? '0
                  : (POS_W+1)'(pos_l_reg) - (POS_W+1)'(ref_l_reg);
    assign diff_r = (restart || first_item_reg) ? '0
                  : (POS_W+1)'(pos_r_reg) - (POS_W+1)'(ref_r_reg);
    assign accum_l_sum = accum_l_reg + ACCUM_WIDTH'(diff_l);
    assign accum_r_sum = accum_r_reg + ACCUM_WIDTH'(diff_r);

    assign digit = rpt_sh_reg[DIGIT_W-1:0];
    assign pp_l  = mcand_l_reg * digit;
    assign pp_r  = mcand_r_reg * digit;

    always_comb
    begin
        state_next        = state_reg;
        low_mark_next     = low_mark_reg;
        high_mark_next    = high_mark_reg;
        span_next         = span_reg;
        rpt_next          = rpt_reg;
        pause_next        = pause_reg;
        wraps_l_next      = wraps_l_reg;
        wraps_r_next      = wraps_r_reg;
        prev_l_next       = prev_l_reg;
        prev_r_next       = prev_r_reg;
        ref_l_next        = ref_l_reg;
        ref_r_next        = ref_r_reg;
        accum_l_next      = accum_l_reg;
        accum_r_next      = accum_r_reg;
        first_item_next   = first_item_reg;
        raw_l_next        = raw_l_reg;
        raw_r_next        = raw_r_reg;
        pause_hit_next    = pause_hit_reg;
        pos_l_next        = pos_l_reg;
        pos_r_next        = pos_r_reg;
        restart_next      = restart_reg;
        mcand_l_next      = mcand_l_reg;
        mcand_r_next      = mcand_r_reg;
        prod_l_next       = prod_l_reg;
        prod_r_next       = prod_r_reg;
        rpt_sh_next       = rpt_sh_reg;
        step_next         = step_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cfg_write)
        begin
            case (cfg_idx)
                wheel_odo_pkg::REG_WRAP_LOW_MARK:    low_mark_next  = pwdata[MARK_W-1:0];
                wheel_odo_pkg::REG_WRAP_HIGH_MARK:   high_mark_next = pwdata[MARK_W-1:0];
                wheel_odo_pkg::REG_COUNT_SPAN:       span_next      = pwdata[SPAN_W-1:0];
                wheel_odo_pkg::REG_RADIANS_PER_TICK: rpt_next       = pwdata[RPT_W-1:0];
                wheel_odo_pkg::REG_PAUSE_LIMIT_MS:   pause_next     = pwdata[PAUSE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    wraps_l_next = wrap_update(sample.count_left, prev_l_reg, wraps_l_reg,
                                               low_mark_reg, high_mark_reg);
                    wraps_r_next = wrap_update(sample.count_right, prev_r_reg, wraps_r_reg,
                                               low_mark_reg, high_mark_reg);
                    prev_l_next    = sample.count_left;
                    prev_r_next    = sample.count_right;
                    raw_l_next     = sample.count_left;
                    raw_r_next     = sample.count_right;
                    pause_hit_next = sample.elapsed_ms > pause_reg;
                    state_next     = S_POS;
                end
            end
            S_POS:
            begin
                pos_l_next = pos_l_calc;
                pos_r_next = pos_r_calc;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                accum_l_next    = accum_l_sum;
                accum_r_next    = accum_r_sum;
                ref_l_next      = pos_l_reg;
                ref_r_next      = pos_r_reg;
                first_item_next = 1'b0;
                restart_next    = restart;
                mcand_l_next    = PROD_W'($signed(accum_l_sum));
                mcand_r_next    = PROD_W'($signed(accum_r_sum));
                prod_l_next     = '0;
                prod_r_next     = '0;
                rpt_sh_next     = rpt_reg;
                step_next       = '0;
                state_next      = S_MUL;
            end
            S_MUL:
            begin
                // low PROD_W bits of the product are all that matter
                prod_l_next  = prod_l_reg + pp_l[PROD_W-1:0];
                prod_r_next  = prod_r_reg + pp_r[PROD_W-1:0];
                mcand_l_next = mcand_l_reg << DIGIT_W;
                mcand_r_next = mcand_r_reg << DIGIT_W;
                rpt_sh_next  = rpt_sh_reg >> DIGIT_W;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.ticks_left   = OUT_W'(accum_l_reg);
                    result_next.ticks_right  = OUT_W'(accum_r_reg);
                    result_next.angle_left   = prod_l_reg[wheel_odo_pkg::ANGLE_SHIFT +: OUT_W];
                    result_next.angle_right  = prod_r_reg[wheel_odo_pkg::ANGLE_SHIFT +: OUT_W];
                    result_next.restart_seen = restart_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            low_mark_reg     <= wheel_odo_pkg::WRAP_LOW_MARK_RST;
            high_mark_reg    <= wheel_odo_pkg::WRAP_HIGH_MARK_RST;
            span_reg         <= wheel_odo_pkg::COUNT_SPAN_RST;
            rpt_reg          <= wheel_odo_pkg::RADIANS_PER_TICK_RST;
            pause_reg        <= wheel_odo_pkg::PAUSE_LIMIT_MS_RST;
            wraps_l_reg      <= '0;
            wraps_r_reg      <= '0;
            prev_l_reg       <= '0;
            prev_r_reg       <= '0;
            ref_l_reg        <= '0;
            ref_r_reg        <= '0;
            accum_l_reg      <= '0;
            accum_r_reg      <= '0;
            first_item_reg   <= 1'b1;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            low_mark_reg     <= low_mark_next;
            high_mark_reg    <= high_mark_next;
            span_reg         <= span_next;
            rpt_reg          <= rpt_next;
            pause_reg        <= pause_next;
            wraps_l_reg      <= wraps_l_next;
            wraps_r_reg      <= wraps_r_next;
            prev_l_reg       <= prev_l_next;
            prev_r_reg       <= prev_r_next;
            ref_l_reg        <= ref_l_next;
            ref_r_reg        <= ref_r_next;
            accum_l_reg      <= accum_l_next;
            accum_r_reg      <= accum_r_next;
            first_item_reg   <= first_item_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_l_reg     <= raw_l_next;
        raw_r_reg     <= raw_r_next;
        pause_hit_reg <= pause_hit_next;
        pos_l_reg     <= pos_l_next;
        pos_r_reg     <= pos_r_next;
        restart_reg   <= restart_next;
        mcand_l_reg   <= mcand_l_next;
        mcand_r_reg   <= mcand_r_next;
        prod_l_reg    <= prod_l_next;
        prod_r_reg    <= prod_r_next;
        rpt_sh_reg    <= rpt_sh_next;
        result_reg    <= result_next;
    end

    a_take_starts_pos: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> state_reg == S_POS)
        else $error("sample transfer did not start the position stage");

    a_mul_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |=> state_reg == S_MUL && step_reg == '0)
        else $error("multiplier entered without a cleared step count");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the output stage");

    a_restart_adds_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC && restart |=>
            accum_l_reg == $past(accum_l_reg) && accum_r_reg == $past(accum_r_reg))
        else $error("restart changed an accumulator");

    a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |=> !first_item_reg)
        else $error("first-sample flag still set after accumulate");

endmodule
